[design/dd_pkg.sv]
// ----------------------------------------------------------------------------
// dd_pkg
// Shared constants and tables for the Gregorian date difference core.
// ----------------------------------------------------------------------------
package dd_pkg;

   // Field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DIST_W  = 22;

   // Largest year taken as given; later years clamp to it
   localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

   // Internal widths, sized for years up to MAX_YEAR
   localparam int CENT_W    = 7;   // year / 100, up to 99, and ceil, up to 100
   localparam int QUAD_W    = 12;  // ceil(year / 4), up to 2500
   localparam int LEAPS_W   = 12;  // leap years before a year, up to 2425
   localparam int DOY_W     = 9;   // day of year, up to 459
   localparam int ORDINAL_W = 22;  // day ordinal, below 3.66 million

   // Reciprocal of 100: floor(x * 5243 / 2^19) == x / 100 for x below 43690
   localparam logic [12:0] RECIP_100  = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          RECIP_PROD_W = YEAR_W + 13;

   // Month codes that bear on the leap day
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

   // Days in the months before month m of a common year; months past 12 count 31
   localparam logic [DOY_W-1:0] DAYS_BEFORE_MONTH [16] = '{
      9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd427
   };

   // One date as it travels down the pipe
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

endpackage

[design/date_difference_days_core.sv]
// ----------------------------------------------------------------------------
// date_difference_days_core
// Absolute number of days between two proleptic Gregorian dates.
// ----------------------------------------------------------------------------
// Four-stage pipeline: a date pair enters on any cycle where start is high,
// and its distance appears on rsp_day_distance with the rsp_valid strobe, for
// one cycle, once it has passed the four register stages. busy is held low, so
// one pair is accepted every cycle, and no stage ever waits.
// Each stage holds at most one constant multiply (the divide by 100 in stage
// one, the multiply by 100 in stage two, the multiply by 365 in stage three).
// Results cannot be held off by the receiver. Each date becomes a day ordinal
// from 1 January of year 0; years above 9999 clamp to 9999, days and months
// are not checked (month 0 counts as January, months past 12 add 31 days
// each).
module date_difference_days_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dd_pkg::DAY_W-1:0]      req_day_a,
   input  logic [dd_pkg::MONTH_W-1:0]    req_month_a,
   input  logic [dd_pkg::YEAR_W-1:0]     req_year_a,
   input  logic [dd_pkg::DAY_W-1:0]      req_day_b,
   input  logic [dd_pkg::MONTH_W-1:0]    req_month_b,
   input  logic [dd_pkg::YEAR_W-1:0]     req_year_b,
   output logic                          rsp_valid,
   output logic [dd_pkg::DIST_W-1:0]     rsp_day_distance
);

   // Stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   // Stage 1: clamped date and year / 100
   dd_pkg::date_type                 s1_date_in  [2];
   dd_pkg::date_type                 s1_date_ff  [2];
   logic [dd_pkg::CENT_W-1:0]        s1_cent_in  [2];
   logic [dd_pkg::CENT_W-1:0]        s1_cent_ff  [2];

   // Stage 2: year, leap years before it, day of year
   logic [dd_pkg::YEAR_W-1:0]        s2_year_in  [2];
   logic [dd_pkg::YEAR_W-1:0]        s2_year_ff  [2];
   logic [dd_pkg::LEAPS_W-1:0]       s2_leaps_in [2];
   logic [dd_pkg::LEAPS_W-1:0]       s2_leaps_ff [2];
   logic [dd_pkg::DOY_W-1:0]         s2_doy_in   [2];
   logic [dd_pkg::DOY_W-1:0]         s2_doy_ff   [2];

   // Stage 3: day ordinal
   logic [dd_pkg::ORDINAL_W-1:0]     s3_ord_in   [2];
   logic [dd_pkg::ORDINAL_W-1:0]     s3_ord_ff   [2];

   // Stage 4: distance
   logic [dd_pkg::DIST_W-1:0]        s4_dist_in;
   logic [dd_pkg::DIST_W-1:0]        s4_dist_ff;

   dd_pkg::date_type                 raw_date    [2];

   // Never stall the requester
   assign busy = 1'b0;

   assign raw_date[0] = '{day: req_day_a, month: req_month_a, year: req_year_a};
   assign raw_date[1] = '{day: req_day_b, month: req_month_b, year: req_year_b};

   // Stage 1: clamp year, divide by 100 through the reciprocal
   always_comb begin
      logic [dd_pkg::RECIP_PROD_W-1:0] prod;
      for (int i = 0; i < 2; i++) begin
         s1_date_in[i] = raw_date[i];
         if (raw_date[i].year > dd_pkg::MAX_YEAR) begin
            s1_date_in[i].year = dd_pkg::MAX_YEAR;
         end
         prod = dd_pkg::RECIP_PROD_W'(s1_date_in[i].year) *
                dd_pkg::RECIP_PROD_W'(dd_pkg::RECIP_100);
         s1_cent_in[i] = dd_pkg::CENT_W'(prod >> dd_pkg::RECIP_SHIFT);
      end
   end

   // Stage 2: leap rule, leap count and day of year
   always_comb begin
      logic [dd_pkg::YEAR_W-1:0]   rem100;
      logic                        leap;
      logic [dd_pkg::CENT_W-1:0]   cent_ceil;
      logic [dd_pkg::YEAR_W:0]     quad_sum;
      logic [dd_pkg::QUAD_W-1:0]   quad_ceil;
      logic [dd_pkg::CENT_W:0]     four_sum;
      logic [dd_pkg::DOY_W-1:0]    doy;
      for (int i = 0; i < 2; i++) begin
         rem100    = s1_date_ff[i].year -
                     dd_pkg::YEAR_W'(s1_cent_ff[i]) * dd_pkg::YEAR_W'(100);
         // Leap: divisible by 4 and not by 100, or divisible by 400
         if (rem100 == '0) begin
            leap = (s1_cent_ff[i][1:0] == 2'b00);
         end else begin
            leap = (s1_date_ff[i].year[1:0] == 2'b00);
         end
         cent_ceil = s1_cent_ff[i] + dd_pkg::CENT_W'(rem100 != '0);
         quad_sum  = {1'b0, s1_date_ff[i].year} + (dd_pkg::YEAR_W+1)'(3);
         quad_ceil = dd_pkg::QUAD_W'(quad_sum >> 2);
         four_sum  = {1'b0, cent_ceil} + (dd_pkg::CENT_W+1)'(3);
         s2_leaps_in[i] = quad_ceil - dd_pkg::LEAPS_W'(cent_ceil) +
                          dd_pkg::LEAPS_W'(four_sum >> 2);
         doy = dd_pkg::DAYS_BEFORE_MONTH[s1_date_ff[i].month] +
               dd_pkg::DOY_W'(s1_date_ff[i].day);
         if (leap && (s1_date_ff[i].month > dd_pkg::MONTH_FEB)) begin
            doy = doy + dd_pkg::DOY_W'(1);
         end
         s2_doy_in[i]  = doy;
         s2_year_in[i] = s1_date_ff[i].year;
      end
   end

   // Stage 3: ordinal = 365 * year + leaps + day of year
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s3_ord_in[i] = dd_pkg::ORDINAL_W'(s2_year_ff[i]) * dd_pkg::ORDINAL_W'(365) +
                        dd_pkg::ORDINAL_W'(s2_leaps_ff[i]) +
                        dd_pkg::ORDINAL_W'(s2_doy_ff[i]);
      end
   end

   // Stage 4: absolute difference; ordinals stay below the 22-bit limit
   always_comb begin
      if (s3_ord_ff[0] >= s3_ord_ff[1]) begin
         s4_dist_in = dd_pkg::DIST_W'(s3_ord_ff[0] - s3_ord_ff[1]);
      end else begin
         s4_dist_in = dd_pkg::DIST_W'(s3_ord_ff[1] - s3_ord_ff[0]);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         s1_date_ff[i]  <= s1_date_in[i];
         s1_cent_ff[i]  <= s1_cent_in[i];
         s2_year_ff[i]  <= s2_year_in[i];
         s2_leaps_ff[i] <= s2_leaps_in[i];
         s2_doy_ff[i]   <= s2_doy_in[i];
         s3_ord_ff[i]   <= s3_ord_in[i];
      end
      s4_dist_ff <= s4_dist_in;
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_day_distance = s4_dist_ff;

   // Check: every accepted transaction yields a response strobe
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted transaction produced no response");

   // Check: no strobe without a transaction in the last stage
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s3_valid_ff))
      else $error("response strobe without a transaction");

   // Check: equal dates give zero distance
   a_equal_dates: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_day_a == req_day_b && req_month_a == req_month_b &&
       req_year_a == req_year_b) |-> ##4 (rsp_day_distance == '0))
      else $error("equal dates gave a nonzero distance");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives date pairs into date_difference_days_core in random bursts and gaps.
// A scoreboard works out each day distance on its own and checks the strobed
// results in order against it.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned YEAR_CAP  = 9999;
   localparam int unsigned DIST_CAP  = 4194303;
   localparam int          NUM_RANDOM = 1850;
   localparam int          PIPE_DRAIN = 8;
   localparam int          DRAIN_LIMIT = 1000;

   // Month numbers for the month lengths and the random month range
   localparam logic [dd_pkg::MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [dd_pkg::MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [dd_pkg::MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [dd_pkg::MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [dd_pkg::MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [dd_pkg::MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct {
      dd_pkg::date_type a;
      dd_pkg::date_type b;
   } date_pair_type;

   // -------------------------------------------------------------------------
   // Scoreboard: expected distances in arrival order
   // -------------------------------------------------------------------------
   class distance_scoreboard;
      int unsigned distance_q[$];
      int          fail_count;
      int          report_count;

      static function automatic bit is_leap_year(int unsigned y);
         return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      endfunction

      // length of month m in a common year; month numbers past December are 31
      static function automatic int unsigned common_month_days(int unsigned m);
         if (m == dd_pkg::MONTH_FEB)
            return 28;
         if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
            return 30;
         return 31;
      endfunction

      // day ordinal counted from 1 January of year 0, with the year clamped
      static function automatic int unsigned day_ordinal(dd_pkg::date_type dt);
         int unsigned y;
         int unsigned ord;
         y = dt.year;
         if (y > YEAR_CAP)
            y = YEAR_CAP;
         ord = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + dt.day;
         for (int unsigned m = 1; m < dt.month; m++)
            ord += common_month_days(m);
         if (dt.month > dd_pkg::MONTH_FEB && is_leap_year(y))
            ord += 1;
         return ord;
      endfunction

      function void note_pair(dd_pkg::date_type a, dd_pkg::date_type b);
         int unsigned oa;
         int unsigned ob;
         int unsigned diff;
         oa = day_ordinal(a);
         ob = day_ordinal(b);
         diff = (oa >= ob) ? oa - ob : ob - oa;
         if (diff > DIST_CAP)
            diff = DIST_CAP;
         distance_q.push_back(diff);
      endfunction

      function void check_distance(logic [dd_pkg::DIST_W-1:0] got);
         int unsigned want;
         if (distance_q.size() == 0) begin
            fail_count++;
            if (report_count < 10) begin
               report_count++;
               $display("ERROR: unexpected distance %0d with nothing pending", got);
            end
            return;
         end
         want = distance_q.pop_front();
         if (got !== want[dd_pkg::DIST_W-1:0]) begin
            fail_count++;
            if (report_count < 10) begin
               report_count++;
               $display("ERROR: day_distance expected %0d, got %0d", want, got);
            end
         end
      endfunction

      function int pending();
         return distance_q.size();
      endfunction

      // count expectations that never came back
      function void close_out();
         if (distance_q.size() != 0) begin
            fail_count += distance_q.size();
            $display("ERROR: %0d distances never arrived", distance_q.size());
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and signals
   // -------------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [dd_pkg::DAY_W-1:0]   req_day_a;
   logic [dd_pkg::MONTH_W-1:0] req_month_a;
   logic [dd_pkg::YEAR_W-1:0]  req_year_a;
   logic [dd_pkg::DAY_W-1:0]   req_day_b;
   logic [dd_pkg::MONTH_W-1:0] req_month_b;
   logic [dd_pkg::YEAR_W-1:0]  req_year_b;
   logic                       rsp_valid;
   logic [dd_pkg::DIST_W-1:0]  rsp_day_distance;

   distance_scoreboard sb = new();

   int burst_left;

   date_difference_days_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_day_a        (req_day_a),
      .req_month_a      (req_month_a),
      .req_year_a       (req_year_a),
      .req_day_b        (req_day_b),
      .req_month_b      (req_month_b),
      .req_year_b       (req_year_b),
      .rsp_valid        (rsp_valid),
      .rsp_day_distance (rsp_day_distance)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Observe accepted transactions and strobed results
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_pair('{req_day_a, req_month_a, req_year_a},
                      '{req_day_b, req_month_b, req_year_b});
      if (!reset && rsp_valid)
         sb.check_distance(rsp_day_distance);
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic dd_pkg::date_type make_date(int unsigned d, int unsigned m,
                                                  int unsigned y);
      dd_pkg::date_type dt;
      dt.day   = d[dd_pkg::DAY_W-1:0];
      dt.month = m[dd_pkg::MONTH_W-1:0];
      dt.year  = y[dd_pkg::YEAR_W-1:0];
      return dt;
   endfunction

   // mostly real calendar dates, some near the year clamp or year 0, some raw bits
   function automatic dd_pkg::date_type random_date();
      int unsigned pick;
      int unsigned y;
      int unsigned m;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         y = $urandom_range(0, YEAR_CAP);
         m = $urandom_range(MONTH_JAN, MONTH_DEC);
         len = distance_scoreboard::common_month_days(m);
         if (m == dd_pkg::MONTH_FEB && distance_scoreboard::is_leap_year(y))
            len = 29;
         return make_date($urandom_range(1, len), m, y);
      end
      if (pick < 82) begin
         y = ($urandom_range(0, 1) == 1) ? $urandom_range(9980, 16383)
                                         : $urandom_range(0, 20);
         return make_date($urandom_range(0, 31), $urandom_range(0, 15), y);
      end
      return make_date($urandom, $urandom, $urandom);
   endfunction

   // present one pair at a clock edge and hold it until taken
   task automatic send_pair(date_pair_type p);
      int gap;
      req_day_a   <= p.a.day;
      req_month_a <= p.a.month;
      req_year_a  <= p.a.year;
      req_day_b   <= p.b.day;
      req_month_b <= p.b.month;
      req_year_b  <= p.b.year;
      start       <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      // end of burst: drop start for a random gap, which may be zero
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_dates(int unsigned da, int unsigned ma, int unsigned ya,
                             int unsigned db, int unsigned mb, int unsigned yb);
      date_pair_type p;
      p.a = make_date(da, ma, ya);
      p.b = make_date(db, mb, yb);
      send_pair(p);
   endtask

   // hold off until every pending transaction has returned or DRAIN_LIMIT runs out
   task automatic drain();
      start <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
         @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      date_pair_type p;
      reset       = 1'b1;
      start       = 1'b0;
      req_day_a   = '0;
      req_month_a = '0;
      req_year_a  = '0;
      req_day_b   = '0;
      req_month_b = '0;
      req_year_b  = '0;
      burst_left  = 12;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, leap rules, clamped years, odd days and months
      send_dates( 1,  1,     0,  1,  1,     0);
      send_dates( 0,  0,     0, 31, 15, 16383);
      send_dates(31, 12,  9999,  1,  1,     0);
      send_dates( 1,  1,     0, 31, 12,  9999);
      send_dates( 1,  1, 10000,  1,  1,  9999);
      send_dates( 1,  1, 16383,  1,  1,  9999);
      send_dates(28,  2,  2000,  1,  3,  2000);
      send_dates(28,  2,  1900,  1,  3,  1900);
      send_dates(29,  2,  2024,  1,  3,  2023);
      send_dates( 1,  3,     0,  1,  1,     1);
      send_dates( 1,  0,  2020,  1,  1,  2020);
      send_dates( 1, 13,  2020,  1,  1,  2021);
      send_dates( 1, 15,  2021, 31, 14,  2019);
      send_dates( 0,  5,  1600, 31,  4,  1600);
      send_dates(31,  2,  2100,  3,  3,  2100);
      send_dates(31, 15,  9999,  0,  0, 16383);
      send_dates(15,  6,  1582,  4, 10,  1582);
      send_dates( 1,  1,   400,  1,  1,   800);
      send_dates(31, 12,  1999,  1,  1,  2000);
      send_dates( 1,  1,  8191,  1,  1,  8192);

      // random pairs, with one full pause midway
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM / 2)
            drain();
         p.a = random_date();
         p.b = random_date();
         send_pair(p);
      end

      drain();
      repeat (PIPE_DRAIN) @(posedge clock);
      sb.close_out();
      if (sb.fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
